FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Plain property, checked on every rising edge outside reset.
`define RBG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Same-cycle implication.
`define RBG_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define RBG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RBG_ASSERT(lbl, clk, rstn, prop)
`define RBG_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define RBG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/rbg_pkg.sv
// ----------------------------------------------------------------------------
// Retry backoff gate package
// Widths, codes and request/result types shared by the gate's modules.
// ----------------------------------------------------------------------------
package rbg_pkg;

    localparam int TIME_BITS     = 48;
    localparam int GATE_W        = TIME_BITS + 1;
    localparam int DLY_W         = 32;
    localparam int ERR_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int SHIFT_CAP_DEF = 20;

    typedef enum logic [1:0] {
        ACT_RESET = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_SCHED = 2'd2
    } rbg_action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_BASE   = 3'd1,
        CFG_MAX    = 3'd2,
        CFG_JITTER = 3'd3,
        CFG_BUDGET = 3'd4
    } rbg_cfg_idx_t;

    typedef struct packed {
        logic [1:0]           action;
        logic [TIME_BITS-1:0] now_ms;
        logic [ERR_W-1:0]     error_code;
    } rbg_req_t;

    typedef struct packed {
        logic              may_run;
        logic              status;
        logic [DLY_W-1:0]  delay_out;
        logic [GATE_W-1:0] gate_time;
        logic [DLY_W-1:0]  attempt_count;
        logic [ERR_W-1:0]  last_error;
    } rbg_rsp_t;

    // Handshake between the gate controller and the remainder unit.
    typedef struct packed {
        logic start;
    } rbg_div_ctl_t;

    typedef struct packed {
        logic busy;
    } rbg_div_stat_t;

endpackage

FILE: rtl/core/rbg_mod_unit.sv
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Restoring division, one dividend bit per cycle; keeps the remainder only.
// ----------------------------------------------------------------------------
module rbg_mod_unit
    import rbg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rbg_div_ctl_t         ctl,
    input  logic [TIME_BITS-1:0] dividend,
    input  logic [DLY_W:0]       divisor,
    output rbg_div_stat_t        stat,
    output logic [DLY_W-1:0]     remainder
);

    localparam int CNT_W = $clog2(TIME_BITS + 1);

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] num_reg, num_next;
    logic [DLY_W:0]       den_reg, den_next;
    logic [DLY_W:0]       rem_reg, rem_next;
    logic [DLY_W+1:0]     trial;
    logic [DLY_W+1:0]     diff;

    assign trial = {rem_reg, num_reg[TIME_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        if (ctl.start)
        begin
            cnt_next = CNT_W'(TIME_BITS);
            num_next = dividend;
            den_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            // shift in the next dividend bit, subtract when it fits
            cnt_next = cnt_reg - CNT_W'(1);
            num_next = {num_reg[TIME_BITS-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
                rem_next = diff[DLY_W:0];
            else
                rem_next = trial[DLY_W:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    // remainder is below the divisor, which never exceeds 2^32
    assign remainder = rem_reg[DLY_W-1:0];
    assign stat.busy = (cnt_reg != '0);

endmodule

FILE: rtl/core/retry_backoff_gate_unit.sv
// ----------------------------------------------------------------------------
// Retry backoff gate
// Attempt counter, earliest-run gate and last error with backoff and jitter.
// ----------------------------------------------------------------------------
// One request is processed at a time. Its run is paced by the jitter remainder
// now_ms mod (jitter_max + 1), which the remainder unit resolves one dividend
// bit per cycle. The exponential shift of the base delay runs one bit per
// cycle in parallel with that loop. After it come the states for the first
// ceiling, the jitter add with the second ceiling, the gate sum and budget
// check, and the commit. A result sits in an output register, so a new
// request is taken while the previous result still waits; the block only
// stalls its commit when the output register is still full. Configuration
// writes land at once and are expected only while the block is idle.
`include "assert_macros.svh"

module retry_backoff_gate_unit
    import rbg_pkg::*;
#(
    parameter int SHIFT_CAP = SHIFT_CAP_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DLY_W-1:0]     cfg_data,
    // request channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rbg_req_t             in_data,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output rbg_rsp_t             out_data
);

    localparam int SH_W = $clog2(SHIFT_CAP + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RUN  = 6'b000010,
        S_CAP  = 6'b000100,
        S_JIT  = 6'b001000,
        S_GATE = 6'b010000,
        S_DONE = 6'b100000
    } rbg_state_t;

    // configuration registers
    logic             backoff_mode_reg;
    logic [DLY_W-1:0] base_delay_reg;
    logic [DLY_W-1:0] max_delay_reg;
    logic [DLY_W-1:0] jitter_max_reg;
    logic [DLY_W-1:0] attempt_budget_reg;

    // architectural state
    logic [DLY_W-1:0]  attempts_reg, attempts_next;
    logic [GATE_W-1:0] earliest_reg, earliest_next;
    logic [ERR_W-1:0]  last_err_reg, last_err_next;

    // control
    rbg_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // per-request working registers
    logic [1:0]           act_reg, act_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [ERR_W-1:0]     err_reg, err_next;
    logic [DLY_W-1:0]     delay_reg, delay_next;
    logic [SH_W-1:0]      shift_reg, shift_next;
    logic [GATE_W-1:0]    gate_cand_reg, gate_cand_next;
    logic                 budget_hit_reg, budget_hit_next;
    rbg_rsp_t             out_data_reg, out_data_next;

    // remainder unit
    rbg_div_ctl_t     div_ctl;
    rbg_div_stat_t    div_stat;
    logic [DLY_W-1:0] jitter_rem;

    // datapath helpers
    logic [DLY_W-1:0]  count_sel;
    logic [SH_W-1:0]   shift_amt;
    logic [DLY_W:0]    jit_sum;
    logic [DLY_W-1:0]  jit_sat;
    logic              commit;
    logic              status_new;
    logic              may_run_new;

    function automatic logic [DLY_W-1:0] apply_ceiling(
        input logic [DLY_W-1:0] d,
        input logic [DLY_W-1:0] ceil_val
    );
        if (ceil_val != '0 && d > ceil_val)
            return ceil_val;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes; indexes past the list are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backoff_mode_reg   <= 1'b0;
            base_delay_reg     <= '0;
            max_delay_reg      <= '0;
            jitter_max_reg     <= '0;
            attempt_budget_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MODE:   backoff_mode_reg   <= cfg_data[0];
                CFG_BASE:   base_delay_reg     <= cfg_data;
                CFG_MAX:    max_delay_reg      <= cfg_data;
                CFG_JITTER: jitter_max_reg     <= cfg_data;
                CFG_BUDGET: attempt_budget_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Jitter remainder: now_ms mod (jitter_max + 1). A zero jitter limit
    // divides by one, so the remainder is zero and no special case is needed.
    // ------------------------------------------------------------------
    assign div_ctl.start = (state_reg == S_IDLE) && in_valid;

    rbg_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (in_data.now_ms),
        .divisor   ({1'b0, jitter_max_reg} + {{DLY_W{1'b0}}, 1'b1}),
        .stat      (div_stat),
        .remainder (jitter_rem)
    );

    // A reset request computes its delay for attempt count zero.
    assign count_sel = (in_data.action == ACT_RESET) ? '0 : attempts_reg;
    assign shift_amt = (count_sel > DLY_W'(SHIFT_CAP)) ? SH_W'(SHIFT_CAP)
                                                       : count_sel[SH_W-1:0];

    // Saturating jitter add.
    assign jit_sum = {1'b0, delay_reg} + {1'b0, jitter_rem};
    assign jit_sat = jit_sum[DLY_W] ? '1 : jit_sum[DLY_W-1:0];

    assign in_ready = (state_reg == S_IDLE);
    assign commit   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // ------------------------------------------------------------------
    // State update at commit, from the latched action.
    // ------------------------------------------------------------------
    always_comb
    begin
        attempts_next = attempts_reg;
        earliest_next = earliest_reg;
        last_err_next = last_err_reg;
        status_new    = 1'b0;
        unique case (act_reg)
            ACT_RESET:
            begin
                attempts_next = '0;
                earliest_next = '0;
                last_err_next = '0;
            end
            ACT_SCHED:
            begin
                last_err_next = err_reg;
                if (budget_hit_reg)
                    status_new = 1'b1;
                else
                begin
                    // counter wraps on overflow
                    attempts_next = attempts_reg + DLY_W'(1);
                    earliest_next = gate_cand_reg;
                end
            end
            default:
                ;   // query, and the unused code, leave state alone
        endcase
        if (!commit)
        begin
            attempts_next = attempts_reg;
            earliest_next = earliest_reg;
            last_err_next = last_err_reg;
        end
    end

    assign may_run_new = ({1'b0, now_reg} >= earliest_next);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        act_next        = act_reg;
        now_next        = now_reg;
        err_next        = err_reg;
        delay_next      = delay_reg;
        shift_next      = shift_reg;
        gate_cand_next  = gate_cand_reg;
        budget_hit_next = budget_hit_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // latch the request, seed the delay with the floored base
                    act_next   = in_data.action;
                    now_next   = in_data.now_ms;
                    err_next   = in_data.error_code;
                    delay_next = (base_delay_reg == '0) ? DLY_W'(1) : base_delay_reg;
                    shift_next = backoff_mode_reg ? shift_amt : '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                // one doubling per cycle; any bit shifted out saturates
                if (shift_reg != '0)
                begin
                    delay_next = delay_reg[DLY_W-1] ? '1 : {delay_reg[DLY_W-2:0], 1'b0};
                    shift_next = shift_reg - SH_W'(1);
                end
                else if (!div_stat.busy)
                    state_next = S_CAP;
            end
            S_CAP:
            begin
                delay_next = apply_ceiling(delay_reg, max_delay_reg);
                state_next = S_JIT;
            end
            S_JIT:
            begin
                delay_next = apply_ceiling(jit_sat, max_delay_reg);
                state_next = S_GATE;
            end
            S_GATE:
            begin
                gate_cand_next  = {1'b0, now_reg} + {{(GATE_W-DLY_W){1'b0}}, delay_reg};
                budget_hit_next = (attempt_budget_reg != '0) &&
                                  (attempts_reg >= attempt_budget_reg);
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (commit)
                begin
                    out_data_next.may_run       = may_run_new;
                    out_data_next.status        = status_new;
                    out_data_next.delay_out     = delay_reg;
                    out_data_next.gate_time     = earliest_next;
                    out_data_next.attempt_count = attempts_next;
                    out_data_next.last_error    = last_err_next;
                    out_valid_next              = 1'b1;
                    state_next                  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            attempts_reg  <= '0;
            earliest_reg  <= '0;
            last_err_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            attempts_reg  <= attempts_next;
            earliest_reg  <= earliest_next;
            last_err_reg  <= last_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        now_reg        <= now_next;
        err_reg        <= err_next;
        delay_reg      <= delay_next;
        shift_reg      <= shift_next;
        gate_cand_reg  <= gate_cand_next;
        budget_hit_reg <= budget_hit_next;
        out_data_reg   <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the remainder unit is never restarted mid-run
    `RBG_ASSERT_IMPLY(a_idle_div_free, clk, rst_n, in_ready, !div_stat.busy)
    // a commit always leaves a fresh result and an idle sequencer
    `RBG_ASSERT_NEXT(a_commit_result, clk, rst_n, commit, out_valid_reg && state_reg == S_IDLE)
    // the attempt count only steps by one or clears
    `RBG_ASSERT(a_attempt_step, clk, rst_n, attempts_reg == $past(attempts_reg) || attempts_reg == $past(attempts_reg) + DLY_W'(1) || attempts_reg == '0)
    // the final delay respects a nonzero ceiling
    `RBG_ASSERT_IMPLY(a_delay_ceiling, clk, rst_n, state_reg == S_DONE && max_delay_reg != '0, delay_reg <= max_delay_reg)

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Retry backoff gate testbench
// Drives reset, query and schedule requests through the gate under many
// register settings, predicts every result with a cycle-free model of the
// attempt counter, gate time and remembered error, and checks each result
// field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
    import rbg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Action code outside the defined set; the gate treats it as a query.
    localparam logic [1:0]           ACT_SPARE  = 2'd3;
    // Register index past the end of the register list; writes are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 3'd7;
    localparam logic [63:0]          DLY_MAX    = 64'h0000_0000_FFFF_FFFF;
    localparam logic [TIME_BITS-1:0] TIME_TOP   = {TIME_BITS{1'b1}};
    localparam int                   RANDOM_PHASES     = 12;
    localparam int                   ITEMS_PER_PHASE   = 125;
    localparam int                   LONG_HOLD_CYCLES  = 400;
    localparam int                   WATCHDOG_CYCLES   = 5000;
    localparam int                   SETTLE_CYCLES     = 80;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [DLY_W-1:0]     cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    rbg_req_t             in_data    = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    rbg_rsp_t             out_data;

    retry_backoff_gate_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the registers as the gate sees them.
    logic        mode_reg;
    logic [31:0] base_reg;
    logic [31:0] max_reg;
    logic [31:0] jitter_reg;
    logic [31:0] budget_reg;

    // Shadow copy of the gate state.
    logic [31:0]       tries_made;
    logic [GATE_W-1:0] gate_open_at;
    logic [ERR_W-1:0]  saved_error;

    rbg_req_t queued_reqs[$];           // requests waiting to be offered
    rbg_rsp_t pending_gate_results[$];  // predicted results, oldest first

    int unsigned mismatch_count = 0;
    int          tx_gap;
    int          rx_hold;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          long_holds_asked = 0;
    int          long_holds_done  = 0;
    int          stall_cycles     = 0;

    // Time source for well-formed request streams; most requests advance it.
    logic [TIME_BITS-1:0] clock_ms;
    int                   step_max;
    int                   reset_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp to max_delay; a zero ceiling means no clamp.
    function automatic logic [63:0] clamp_ceiling(logic [63:0] d);
        if (max_reg != 0 && d > {32'd0, max_reg})
            return {32'd0, max_reg};
        return d;
    endfunction

    // Delay for a given attempt count, seeded for jitter by the request time.
    function automatic logic [31:0] backoff_delay(logic [31:0] count,
                                                  logic [TIME_BITS-1:0] seed);
        logic [63:0] d;
        logic [63:0] j;
        int unsigned sh;
        d = (base_reg == 0) ? 64'd1 : {32'd0, base_reg};
        if (mode_reg && count != 0)
        begin
            sh = (count > SHIFT_CAP_DEF) ? SHIFT_CAP_DEF : count;
            d = d << sh;
            if (d > DLY_MAX)
                d = DLY_MAX;
        end
        d = clamp_ceiling(d);
        if (jitter_reg != 0)
        begin
            j = {{(64 - TIME_BITS){1'b0}}, seed} % ({32'd0, jitter_reg} + 64'd1);
            d = d + j;
            if (d > DLY_MAX)
                d = DLY_MAX;
        end
        d = clamp_ceiling(d);
        return d[31:0];
    endfunction

    // Advance the shadow state by one request and return its result.
    function automatic rbg_rsp_t gate_step(rbg_req_t req);
        rbg_rsp_t    r;
        logic [31:0] dly;
        logic        exhausted;
        exhausted = 1'b0;
        if (req.action == ACT_RESET)
        begin
            tries_made   = '0;
            gate_open_at = '0;
            saved_error  = '0;
        end
        dly = backoff_delay(tries_made, req.now_ms);
        if (req.action == ACT_SCHED)
        begin
            if (budget_reg != 0 && tries_made >= budget_reg)
                exhausted = 1'b1;
            else
            begin
                tries_made   = tries_made + 32'd1;
                gate_open_at = {1'b0, req.now_ms} + {{(GATE_W - DLY_W){1'b0}}, dly};
            end
            saved_error = req.error_code;
        end
        r.may_run       = ({1'b0, req.now_ms} >= gate_open_at);
        r.status        = exhausted;
        r.delay_out     = dly;
        r.gate_time     = gate_open_at;
        r.attempt_count = tries_made;
        r.last_error    = saved_error;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idle pattern: mostly back to back, some short gaps, a few long ones.
    // ------------------------------------------------------------------
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offer the next queued request, hold it until taken,
    // and predict its result at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        int tg;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            tg = tx_gap;
            if (in_valid && in_ready)
            begin
                pending_gate_results.push_back(gate_step(in_data));
                tg = tx_steady ? 0 : idle_gap();
            end
            // Slot is free when nothing is offered or the offer was just taken.
            if (!in_valid || in_ready)
            begin
                if (tg > 0)
                begin
                    tg = tg - 1;
                    in_valid <= 1'b0;
                end
                else if (queued_reqs.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= queued_reqs.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            tx_gap <= tg;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken result with the oldest prediction,
    // then pick how long to hold off before taking the next one.
    // ------------------------------------------------------------------
    task automatic check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        rbg_rsp_t exp_r;
        int       nh;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold   <= 0;
        end
        else
        begin
            nh = rx_hold;
            if (out_valid && out_ready)
            begin
                if (pending_gate_results.size() == 0)
                begin
                    $display("%0t: result with none expected: expected nothing, actual %h",
                             $time, out_data);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = pending_gate_results.pop_front();
                    check_field("may_run",       64'(exp_r.may_run),
                                64'(out_data.may_run));
                    check_field("status",        64'(exp_r.status),
                                64'(out_data.status));
                    check_field("delay_out",     64'(exp_r.delay_out),
                                64'(out_data.delay_out));
                    check_field("gate_time",     64'(exp_r.gate_time),
                                64'(out_data.gate_time));
                    check_field("attempt_count", 64'(exp_r.attempt_count),
                                64'(out_data.attempt_count));
                    check_field("last_error",    64'(exp_r.last_error),
                                64'(out_data.last_error));
                end
                nh = rx_steady ? 0 : idle_gap();
            end
            else if (nh > 0)
                nh = nh - 1;
            // A long hold lets the block fill up and push back on requests.
            if (long_holds_asked != long_holds_done)
            begin
                nh = LONG_HOLD_CYCLES;
                long_holds_done <= long_holds_done + 1;
            end
            rx_hold   <= nh;
            out_ready <= (nh == 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no request or result moves for too long.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_CYCLES)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_CYCLES);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register and mirror the masked value in the shadow copy.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_MODE:   mode_reg   = val[0];
            CFG_BASE:   base_reg   = val;
            CFG_MAX:    max_reg    = val;
            CFG_JITTER: jitter_reg = val;
            CFG_BUDGET: budget_reg = val;
            default:    ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all_regs(logic [31:0] mode_v, logic [31:0] base_v,
                                  logic [31:0] max_v, logic [31:0] jit_v,
                                  logic [31:0] budget_v);
        write_reg(CFG_MODE,   mode_v);
        write_reg(CFG_BASE,   base_v);
        write_reg(CFG_MAX,    max_v);
        write_reg(CFG_JITTER, jit_v);
        write_reg(CFG_BUDGET, budget_v);
    endtask

    function automatic void add_req(logic [1:0] act, logic [TIME_BITS-1:0] now,
                                    logic [ERR_W-1:0] err);
        rbg_req_t r;
        r.action     = act;
        r.now_ms     = now;
        r.error_code = err;
        queued_reqs.push_back(r);
    endfunction

    // Hold until every queued request is taken and every result has come.
    task automatic wait_drained();
        while (queued_reqs.size() != 0 || in_valid || pending_gate_results.size() != 0)
            @(posedge clk);
    endtask

    // Register value: zero, all ones, a small value or anything.
    function automatic logic [31:0] pick_reg(int small_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 32'd0;
        if (r < 25)
            return 32'hFFFF_FFFF;
        if (r < 70)
            return $urandom_range(1, small_max);
        return $urandom;
    endfunction

    function automatic logic [TIME_BITS-1:0] next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            clock_ms = clock_ms + TIME_BITS'($urandom_range(0, step_max));
            return clock_ms;
        end
        if (r < 85)
            return TIME_BITS'({$urandom, $urandom});
        if (r < 93)
            return TIME_TOP - TIME_BITS'($urandom_range(0, 3000));
        return TIME_BITS'($urandom_range(0, 3000));
    endfunction

    function automatic void add_random_req();
        int         r;
        logic [1:0] act;
        r = $urandom_range(0, 99);
        if (r < reset_pct)
            act = ACT_RESET;
        else if (r < reset_pct + 5)
            act = ACT_SPARE;
        else if (r < 57)
            act = ACT_SCHED;
        else
            act = ACT_QUERY;
        add_req(act, next_time(), ERR_W'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Sequence: reset, directed phases, then random phases.
    // ------------------------------------------------------------------
    initial
    begin
        logic [31:0] budget_v;
        mode_reg     = 1'b0;
        base_reg     = '0;
        max_reg      = '0;
        jitter_reg   = '0;
        budget_reg   = '0;
        tries_made   = '0;
        gate_open_at = '0;
        saved_error  = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Exponential mode with a zero base (read as 1) and a budget of three.
        // Mode data carries upper bits that the gate must drop.
        write_all_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd3);
        add_req(ACT_RESET, '0,        16'h0000);
        add_req(ACT_QUERY, TIME_TOP,  16'hFFFF);
        add_req(ACT_SCHED, 48'd10,    16'h0001);
        add_req(ACT_QUERY, 48'd10,    16'h0000);
        add_req(ACT_QUERY, 48'd11,    16'h0000);
        add_req(ACT_SCHED, 48'd20,    16'h8000);
        add_req(ACT_SCHED, 48'd21,    16'h00FF);
        add_req(ACT_SCHED, 48'd30,    16'hFFFF);   // budget exhausted
        add_req(ACT_SPARE, 48'd40,    16'h1234);
        add_req(ACT_RESET, TIME_TOP,  16'hAAAA);
        wait_drained();

        // Everything at the top: shift and jitter saturate, gate spills into
        // the extra time bit. A write past the register list must be ignored.
        write_all_regs(32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        write_reg(CFG_SPARE, $urandom);
        add_req(ACT_SCHED, TIME_TOP,  16'h5555);
        add_req(ACT_QUERY, TIME_TOP,  16'h0000);
        add_req(ACT_SCHED, '0,        16'hA5A5);
        add_req(ACT_QUERY, 48'h8000_0000_0000, 16'h0000);
        add_req(ACT_SCHED, 48'd1,     16'h0F0F);
        wait_drained();

        // Fixed mode, ceiling below base plus jitter, budget of one.
        write_all_regs(32'hFFFF_FFFE, 32'd1000, 32'd1500, 32'd700, 32'd1);
        add_req(ACT_SCHED, 48'd123456, 16'd7);
        add_req(ACT_SCHED, 48'd123457, 16'd8);     // budget exhausted
        add_req(ACT_QUERY, 48'd200000, 16'd0);
        add_req(ACT_RESET, 48'd999,    16'd9);
        add_req(ACT_SCHED, 48'd5000,   16'd10);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if ($urandom_range(0, 1) == 0)
                budget_v = 32'd0;
            else if ($urandom_range(0, 3) != 0)
                budget_v = $urandom_range(1, 30);
            else
                budget_v = pick_reg(100);
            write_all_regs($urandom, pick_reg(50), pick_reg(100000), pick_reg(500),
                           budget_v);
            // Every fourth phase runs without idling on either side.
            tx_steady = (ph % 4 == 3);
            rx_steady = (ph % 4 == 3);
            step_max  = ($urandom_range(0, 1) == 0) ? 50 : 5000;
            reset_pct = $urandom_range(0, 8);
            clock_ms  = ($urandom_range(0, 1) == 0)
                        ? TIME_BITS'($urandom_range(0, 1000))
                        : TIME_BITS'({$urandom, $urandom});
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                add_random_req();
            // Stop taking results for a long stretch while requests keep coming.
            if (ph == 2 || ph == 7)
                long_holds_asked = long_holds_asked + 1;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_gate_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/rbg_pkg.sv
rtl/core/rbg_mod_unit.sv
rtl/core/retry_backoff_gate_unit.sv
dv/tb.sv
